[hw/rtl/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int CELL_IDX_W   = $clog2(MAX_WINDOW);
   localparam int AGE_W        = CELL_IDX_W;
   localparam int FILL_W       = CELL_IDX_W + 1;
   localparam int WS_W         = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = WS_W'(MAX_WINDOW);

   // Register index, taken from the word address bits of paddr.
   localparam logic REG_WINDOW_SIZE = 1'b0;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_EVICT,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] value;
      logic [AGE_W-1:0]               age;
      logic                           valid;
   } cell_state_type;

   typedef struct packed {
      cell_op_type                    op;
      logic signed [SAMPLE_WIDTH-1:0] key;
      logic signed [SAMPLE_WIDTH-1:0] victim;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_EVICT,
      ST_INSERT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic req_valid;
      logic full;
      logic slot_free;
   } ctrl_status_type;

   typedef struct packed {
      logic req_ready;
      logic find;
      logic evict;
      logic insert;
      logic emit;
   } ctrl_cmd_type;

   // Effective window length: zero acts as one, large values saturate.
   function automatic logic [FILL_W-1:0] window_len(input logic [WS_W-1:0] ws);
      logic [FILL_W-1:0] k;
      begin
         if (ws == '0) begin
            k = FILL_W'(1);
         end else if (32'(ws) > MAX_WINDOW) begin
            k = FILL_W'(MAX_WINDOW);
         end else begin
            k = FILL_W'(ws);
         end
         return k;
      end
   endfunction

endpackage

[hw/rtl/swm_req_if.sv]
`timescale 1ns / 1ps

interface swm_req_if import swm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           restart;

   modport source(output valid, sample, restart, input ready);
   modport sink(input valid, sample, restart, output ready);
endinterface

[hw/rtl/swm_rsp_if.sv]
`timescale 1ns / 1ps

interface swm_rsp_if import swm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] median;

   modport source(output valid, median, input ready);
   modport sink(input valid, median, output ready);
endinterface

[hw/rtl/sliding_window_median_top.sv]
`timescale 1ns / 1ps

// Sliding-window lower-median filter.
// Input words arrive on req_chan (sample, restart) with a valid/ready handshake.
// Each accepted word yields at most one result word on rsp_chan once the window
// holds k samples (window_size limited to 1..64): the element at ascending index ceil(k/2)-1.
// window_size is register 0 of the APB-style csr_ port; write it only while idle.
// A word with restart set empties the window first and starts a new sequence.
// Without an eviction a word passes the accept, locate, insert and emit steps. The
// result shows on rsp_chan as the controller returns to accept and can be taken at
// the same edge that can accept the following word. With a full window each word
// also evicts its oldest sample, adding a shift step and a second locate step.
// After the window is shrunk, each extra evicted sample adds another shift and locate.
// The cell row shifts by one place in each evict or insert step.
// Reset empties the window, drops any pending result and sets window_size to 64.
// If the receiver stalls, the result stays in the output register and the next
// word is still accepted and processed; it waits in the emit step until the
// output register frees up.

module sliding_window_median_top import swm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swm_req_if.sink               req_chan,
   swm_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Configuration register.
   logic [WS_W-1:0]   window_size_ff;
   logic [WS_W-1:0]   window_size_in;
   logic              csr_write;
   logic [FILL_W-1:0] win_len;
   logic [FILL_W-1:0] win_len_m1;
   logic [CELL_IDX_W-1:0] mid_idx;

   // Window bookkeeping and captured word.
   logic [FILL_W-1:0]              fill_ff;
   logic [FILL_W-1:0]              fill_in;
   logic signed [SAMPLE_WIDTH-1:0] key_ff;
   logic signed [SAMPLE_WIDTH-1:0] key_in;
   logic signed [SAMPLE_WIDTH-1:0] victim_ff;
   logic signed [SAMPLE_WIDTH-1:0] victim_in;
   logic [AGE_W-1:0]               oldest_age;

   // Output register.
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] median_ff;
   logic signed [SAMPLE_WIDTH-1:0] median_in;

   logic            take;
   ctrl_status_type status;
   ctrl_cmd_type    cmd;
   cell_ctrl_type   cell_ctrl;

   cell_state_type cell_q      [MAX_WINDOW];
   logic           cell_yields [MAX_WINDOW];
   cell_state_type empty_cell;

   // The APB port always completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE);
   assign window_size_in = csr_write ? csr_pwdata[WS_W-1:0] : window_size_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_SIZE) ?
                       CSR_DATA_W'(window_size_ff) : '0;

   assign win_len    = window_len(window_size_ff);
   assign win_len_m1 = win_len - FILL_W'(1);
   assign mid_idx    = win_len_m1[FILL_W-1:1];

   assign take = req_chan.valid && cmd.req_ready;
   assign req_chan.ready = cmd.req_ready;

   // The same compare means "evict first" while locating and "emit" after
   // insertion, since the window is checked against k in both places.
   assign status.req_valid = req_chan.valid;
   assign status.full      = (fill_ff >= win_len);
   assign status.slot_free = !rsp_valid_ff || rsp_chan.ready;

   swm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Ages of held samples run from zero up to fill-1, so the oldest one is
   // the single valid cell whose age is fill-1.
   assign oldest_age = win_len_m1[AGE_W-1:0] ^ win_len_m1[AGE_W-1:0] ^
                       (fill_ff[AGE_W-1:0] - AGE_W'(1));

   always_comb begin
      victim_in = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (cell_q[i].valid && (cell_q[i].age == oldest_age)) begin
            victim_in = victim_in | cell_q[i].value;
         end
      end
      if (!cmd.find) begin
         victim_in = victim_ff;
      end
   end

   assign key_in = take ? req_chan.sample : key_ff;

   always_comb begin
      fill_in = fill_ff;
      if (take && req_chan.restart) begin
         fill_in = '0;
      end else if (cmd.evict) begin
         fill_in = fill_ff - FILL_W'(1);
      end else if (cmd.insert) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_comb begin
      cell_ctrl.key    = key_ff;
      cell_ctrl.victim = victim_ff;
      if (take && req_chan.restart) begin
         cell_ctrl.op = CELL_CLEAR;
      end else if (cmd.evict) begin
         cell_ctrl.op = CELL_EVICT;
      end else if (cmd.insert) begin
         cell_ctrl.op = CELL_INSERT;
      end else begin
         cell_ctrl.op = CELL_HOLD;
      end
   end

   assign empty_cell = '{value: '0, age: '0, valid: 1'b0};

   // Row of cells in ascending order: insertion shifts toward higher
   // indexes, eviction closes the gap from the right.
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      cell_state_type left_state;
      logic           left_yields;
      cell_state_type right_state;

      if (g == 0) begin : g_first
         assign left_state  = empty_cell;
         assign left_yields = 1'b0;
      end else begin : g_inner_left
         assign left_state  = cell_q[g-1];
         assign left_yields = cell_yields[g-1];
      end

      if (g == MAX_WINDOW - 1) begin : g_last
         assign right_state = empty_cell;
      end else begin : g_inner_right
         assign right_state = cell_q[g+1];
      end

      swm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .left_state  (left_state),
         .left_yields (left_yields),
         .right_state (right_state),
         .state       (cell_q[g]),
         .yields      (cell_yields[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         median_in    = cell_q[mid_idx].value;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.median = median_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      victim_ff <= victim_in;
      median_ff <= median_in;
   end

endmodule

[hw/rtl/swm_cell.sv]
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctrl,
   input  cell_state_type left_state,
   input  logic           left_yields,
   input  cell_state_type right_state,
   output cell_state_type state,
   output logic           yields
);

   cell_state_type state_ff;
   cell_state_type state_in;
   logic           at_or_above_victim;

   // A cell yields to the new key when it is empty or holds a larger value,
   // so equal values end up after the ones already held.
   assign yields = !state_ff.valid || ($signed(state_ff.value) > $signed(ctrl.key));
   assign at_or_above_victim = state_ff.valid &&
                               ($signed(state_ff.value) >= $signed(ctrl.victim));

   always_comb begin
      state_in = state_ff;
      case (ctrl.op)
         CELL_HOLD: begin
            state_in = state_ff;
         end
         CELL_CLEAR: begin
            state_in.valid = 1'b0;
         end
         CELL_EVICT: begin
            if (at_or_above_victim) begin
               state_in = right_state;
            end
         end
         CELL_INSERT: begin
            if (left_yields) begin
               state_in     = left_state;
               state_in.age = left_state.age + AGE_W'(1);
            end else if (yields) begin
               state_in.value = ctrl.key;
               state_in.age   = '0;
               state_in.valid = 1'b1;
            end else begin
               state_in.age = state_ff.age + AGE_W'(1);
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

[hw/rtl/swm_ctrl.sv]
`timescale 1ns / 1ps

module swm_ctrl import swm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = status.full ? ST_EVICT : ST_INSERT;
         end
         ST_EVICT: begin
            state_in = ST_FIND;
         end
         ST_INSERT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.full || status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ST_FIND: begin
            cmd.find = 1'b1;
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
         end
         ST_OUT: begin
            cmd.emit = status.full && status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/swm_checker.sv]
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_median
);

   // A stalled result word is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("result word changed while stalled");

   // Every accepted word keeps the block busy for at least locate, insert and emit.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input taken again before the previous word was processed");

   // A new result appears only as the block returns to accepting input.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result word raised outside the emit step");

   // Reset leaves no result pending and the input open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the result register or controller");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_median (rsp_chan.median)
);
